// File: hdl/gbl_pkg.sv
// shared types, constants and helpers of the separable blur unit
package gbl_pkg;

    localparam int NUM_TAPS = 5;
    localparam int TAP_W    = 16;
    localparam int PIX_W    = 8;
    localparam int POS_W    = 13;
    localparam int DIVD_W   = 44;
    localparam int DIVS_W   = 24;
    localparam int CNT_W    = 6;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam logic [2:0] REG_HALF   = 3'd0;
    localparam logic [2:0] REG_TAP_C  = 3'd1;
    localparam logic [2:0] REG_TAP_1  = 3'd2;
    localparam logic [2:0] REG_TAP_2  = 3'd3;
    localparam logic [2:0] REG_TAP_3  = 3'd4;
    localparam logic [2:0] REG_TAP_4  = 3'd5;
    localparam logic [2:0] REG_WIDTH  = 3'd6;
    localparam logic [2:0] REG_HEIGHT = 3'd7;

    localparam logic CMD_PIXEL = 1'b0;

    typedef logic [TAP_W-1:0] t_taps [NUM_TAPS];

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             row_last;
        logic             frame_last;
    } t_task;

    typedef struct packed {
        logic             en;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic [PIX_W-1:0] pix;
    } t_pix_wr;

    function automatic logic [TAP_W-1:0] tap_weight(input t_taps taps, input logic [3:0] mag);
        logic [TAP_W-1:0] w;
        w = '0;
        if (mag <= 4'(NUM_TAPS - 1)) begin
            w = taps[mag[2:0]];
        end
        return w;
    endfunction

endpackage

// File: hdl/gbl_stream_if.sv
// pixel and result stream interfaces
interface gbl_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] pixel_in;

    modport source (output valid, command, pixel_in, input ready);
    modport sink (input valid, command, pixel_in, output ready);
endinterface

interface gbl_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_out;
    logic       row_last;
    logic       frame_last;

    modport source (output valid, pixel_out, row_last, frame_last, input ready);
    modport sink (input valid, pixel_out, row_last, frame_last, output ready);
endinterface

// File: hdl/gbl_front.sv
// front end: frame counters, pixel store writes and output task issue
module gbl_front #(
    parameter int MAX_HALF_WINDOW = 4,
    parameter int MAX_WIDTH       = 2048,
    parameter int MAX_HEIGHT      = 2048,
    localparam int HB = $clog2(MAX_HALF_WINDOW + 1),
    localparam int CB = $clog2(MAX_WIDTH),
    localparam int RB = $clog2(MAX_HEIGHT)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    gbl_in_if.sink           i_in,
    input  logic [2:0]       i_half,
    input  logic [11:0]      i_width,
    input  logic [11:0]      i_height,
    input  logic             i_back_quiet,
    input  logic             i_q_full,
    output gbl_pkg::t_task   o_task,
    output logic             o_push,
    output gbl_pkg::t_pix_wr o_wr,
    output logic [HB-1:0]    o_fr_half,
    output logic [CB:0]      o_fr_w,
    output logic [RB:0]      o_fr_h
);
    import gbl_pkg::*;

    localparam int GB = $clog2(MAX_WIDTH * MAX_HEIGHT + 1) + 1;
    localparam int PB = HB + CB + 1;

    logic [HB-1:0] r_fr_half;
    logic [CB:0]   r_fr_w;
    logic [RB:0]   r_fr_h;
    logic [CB-1:0] r_in_col, n_in_col;
    logic [RB:0]   r_in_row, n_in_row;
    logic [CB-1:0] r_out_col, n_out_col;
    logic [RB-1:0] r_out_row, n_out_row;
    logic [GB-1:0] r_gap, n_gap;

    logic [HB-1:0] sat_half, eff_half;
    logic [CB:0]   sat_w, eff_w;
    logic [RB:0]   sat_h, eff_h;
    logic [PB-1:0] prod;
    logic [GB-1:0] delay;
    logic          frame_start, acc, latch, in_done, store, emit, last, out_rl;

    assign sat_half = ({29'd0, i_half} > 32'(MAX_HALF_WINDOW)) ? HB'(MAX_HALF_WINDOW)
                                                               : HB'(i_half);
    assign sat_w = (i_width == 12'd0) ? (CB+1)'(1) :
                   ({20'd0, i_width} > 32'(MAX_WIDTH)) ? (CB+1)'(MAX_WIDTH) : (CB+1)'(i_width);
    assign sat_h = (i_height == 12'd0) ? (RB+1)'(1) :
                   ({20'd0, i_height} > 32'(MAX_HEIGHT)) ? (RB+1)'(MAX_HEIGHT)
                                                          : (RB+1)'(i_height);

    assign frame_start = (r_in_row == '0) && (r_in_col == '0) &&
                         (r_out_row == '0) && (r_out_col == '0);
    assign i_in.ready  = !i_q_full && (!frame_start || i_back_quiet);
    assign acc         = i_in.valid && i_in.ready;
    assign latch       = (i_in.command == CMD_PIXEL) && frame_start;

    assign eff_half = latch ? sat_half : r_fr_half;
    assign eff_w    = latch ? sat_w : r_fr_w;
    assign eff_h    = latch ? sat_h : r_fr_h;
    assign prod     = PB'(eff_half) * PB'(eff_w);
    assign delay    = GB'(prod) + GB'(eff_half);

    assign in_done = r_in_row >= eff_h;
    assign store   = acc && (i_in.command == CMD_PIXEL) && !in_done;
    assign emit    = acc && (store ? ((r_gap + GB'(1)) > delay)
                                   : ((i_in.command != CMD_PIXEL) && in_done));
    assign out_rl  = ((CB+1)'(r_out_col) + (CB+1)'(1)) == eff_w;
    assign last    = out_rl && (((RB+1)'(r_out_row) + (RB+1)'(1)) == eff_h);

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_gap     = r_gap + GB'(store) - GB'(emit);
        if (store) begin
            if (((CB+1)'(r_in_col) + (CB+1)'(1)) == eff_w) begin
                n_in_col = '0;
                n_in_row = r_in_row + (RB+1)'(1);
            end else begin
                n_in_col = r_in_col + CB'(1);
            end
        end
        if (emit) begin
            if (last) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
                n_gap     = '0;
            end else if (out_rl) begin
                n_out_col = '0;
                n_out_row = r_out_row + RB'(1);
            end else begin
                n_out_col = r_out_col + CB'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fr_half <= '0;
            r_fr_w    <= (CB+1)'(640 > MAX_WIDTH ? MAX_WIDTH : 640);
            r_fr_h    <= (RB+1)'(480 > MAX_HEIGHT ? MAX_HEIGHT : 480);
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_gap     <= '0;
        end else begin
            if (acc && latch) begin
                r_fr_half <= sat_half;
                r_fr_w    <= sat_w;
                r_fr_h    <= sat_h;
            end
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_gap     <= n_gap;
        end
    end

    assign o_push           = emit;
    assign o_task.row       = POS_W'(r_out_row);
    assign o_task.col       = POS_W'(r_out_col);
    assign o_task.row_last  = out_rl;
    assign o_task.frame_last = last;
    assign o_wr.en          = store;
    assign o_wr.row         = POS_W'(r_in_row);
    assign o_wr.col         = POS_W'(r_in_col);
    assign o_wr.pix         = i_in.pixel_in;
    assign o_fr_half        = r_fr_half;
    assign o_fr_w           = r_fr_w;
    assign o_fr_h           = r_fr_h;

endmodule

// File: hdl/gbl_fifo.sv
// two-entry task queue between front and back
module gbl_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  gbl_pkg::t_task i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output gbl_pkg::t_task o_data
);
    import gbl_pkg::*;

    t_task      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// File: hdl/gbl_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module gbl_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [gbl_pkg::DIVD_W-1:0]  i_dividend,
    input  logic [gbl_pkg::DIVS_W-1:0]  i_divisor,
    output logic                        o_busy,
    output logic                        o_done,
    output logic [gbl_pkg::DIVD_W-1:0]  o_quot
);
    import gbl_pkg::*;

    logic [DIVD_W-1:0] r_q, n_q;
    logic [DIVS_W-1:0] r_rem, n_rem;
    logic [DIVS_W-1:0] r_dvs;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DIVS_W:0]   trial;
    logic              ge;

    assign trial = {r_rem, r_q[DIVD_W-1]};
    assign ge    = trial >= {1'b0, r_dvs};
    assign n_rem = ge ? DIVS_W'(trial - {1'b0, r_dvs}) : trial[DIVS_W-1:0];
    assign n_q   = {r_q[DIVD_W-2:0], ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// File: hdl/gbl_back.sv
// back end: pixel store, tap sequencer, renormalizing divides, result register
module gbl_back #(
    parameter int MAX_HALF_WINDOW = 4,
    parameter int MAX_WIDTH       = 2048,
    parameter int MAX_HEIGHT      = 2048,
    parameter int FRAC_BITS       = 8,
    localparam int HB = $clog2(MAX_HALF_WINDOW + 1),
    localparam int CB = $clog2(MAX_WIDTH),
    localparam int RB = $clog2(MAX_HEIGHT)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  gbl_pkg::t_task   i_task,
    output logic             o_pop,
    input  gbl_pkg::t_pix_wr i_wr,
    input  logic [HB-1:0]    i_fr_half,
    input  logic [CB:0]      i_fr_w,
    input  logic [RB:0]      i_fr_h,
    input  gbl_pkg::t_taps   i_taps,
    gbl_out_if.source        o_out,
    output logic             o_idle
);
    import gbl_pkg::*;

    localparam int DB   = HB + 1;
    localparam int SW   = POS_W + 2;
    localparam int LB   = $clog2(3 * MAX_HALF_WINDOW + 4);
    localparam int HV_W = PIX_W + FRAC_BITS;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ROW   = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_ACC   = 4'd3;
    localparam logic [3:0] S_HDIV  = 4'd4;
    localparam logic [3:0] S_HWAIT = 4'd5;
    localparam logic [3:0] S_VACC  = 4'd6;
    localparam logic [3:0] S_VDIV  = 4'd7;
    localparam logic [3:0] S_VWAIT = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [PIX_W-1:0] r_mem [2**(LB+CB)];

    logic [3:0]        r_state, n_state;
    t_task             r_task;
    logic signed [DB-1:0] r_dv, r_dh;
    logic [DIVD_W-1:0] r_hdot, r_vdot;
    logic [DIVS_W-1:0] r_hsum, r_vsum;
    logic [PIX_W-1:0]  r_cpix, r_rdata, r_res;
    logic [HV_W-1:0]   r_hval, r_hcen;
    logic              r_inb;
    logic [TAP_W-1:0]  r_wt;
    logic              r_out_valid;
    logic [PIX_W-1:0]  r_out_pix;
    logic              r_out_rl, r_out_fl;

    logic signed [DB-1:0] half_s;
    logic signed [SW-1:0] rr, cc;
    logic                 row_inb, col_inb, dv_end, dh_end, load;
    logic [DB-1:0]        mag_v, mag_h;
    logic [TAP_W-1:0]     wt_v, wt_h;
    logic [LB+CB-1:0]     rd_addr, wr_addr;
    logic [PIX_W+TAP_W-1:0] prod_h;
    logic [HV_W+TAP_W-1:0]  prod_v;
    logic                 div_start, div_busy, div_done;
    logic [DIVD_W-1:0]    div_dividend, div_quot;
    logic [DIVS_W-1:0]    div_divisor;

    assign half_s  = $signed({1'b0, i_fr_half});
    assign rr      = $signed({2'b00, r_task.row}) + $signed({{(SW-DB){r_dv[DB-1]}}, r_dv});
    assign cc      = $signed({2'b00, r_task.col}) + $signed({{(SW-DB){r_dh[DB-1]}}, r_dh});
    assign row_inb = !rr[SW-1] && (rr[SW-2:0] < (SW-1)'(i_fr_h));
    assign col_inb = !cc[SW-1] && (cc[SW-2:0] < (SW-1)'(i_fr_w));
    assign dv_end  = (r_dv == half_s);
    assign dh_end  = (r_dh == half_s);
    assign mag_v   = r_dv[DB-1] ? DB'(-r_dv) : DB'(r_dv);
    assign mag_h   = r_dh[DB-1] ? DB'(-r_dh) : DB'(r_dh);
    assign wt_v    = tap_weight(i_taps, 4'(mag_v));
    assign wt_h    = tap_weight(i_taps, 4'(mag_h));
    assign rd_addr = {rr[LB-1:0], cc[CB-1:0]};
    assign wr_addr = {i_wr.row[LB-1:0], i_wr.col[CB-1:0]};
    assign prod_h  = r_rdata * r_wt;
    assign prod_v  = r_hval * wt_v;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[wr_addr] <= i_wr.pix;
        end
        r_rdata <= r_mem[rd_addr];
    end

    assign div_start    = ((r_state == S_HDIV) && (r_hsum != '0)) ||
                          ((r_state == S_VDIV) && (r_vsum != '0));
    assign div_dividend = (r_state == S_HDIV) ? (r_hdot << FRAC_BITS) : r_vdot;
    assign div_divisor  = (r_state == S_HDIV) ? r_hsum : r_vsum;

    gbl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    assign o_pop = (r_state == S_IDLE) && i_q_valid;
    assign load  = (r_state == S_OUT) && (!r_out_valid || o_out.ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_q_valid) n_state = S_ROW;
            S_ROW: begin
                if (row_inb) begin
                    n_state = S_RD;
                end else if (dv_end) begin
                    n_state = S_VDIV;
                end
            end
            S_RD:    n_state = S_ACC;
            S_ACC:   n_state = dh_end ? S_HDIV : S_RD;
            S_HDIV:  n_state = (r_hsum == '0) ? S_VACC : S_HWAIT;
            S_HWAIT: if (div_done) n_state = S_VACC;
            S_VACC:  n_state = dv_end ? S_VDIV : S_ROW;
            S_VDIV:  n_state = (r_vsum == '0) ? S_OUT : S_VWAIT;
            S_VWAIT: if (div_done) n_state = S_OUT;
            S_OUT:   if (load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_task <= i_task;
                r_dv   <= -half_s;
                r_vdot <= '0;
                r_vsum <= '0;
            end
            S_ROW: begin
                r_dh   <= -half_s;
                r_hdot <= '0;
                r_hsum <= '0;
                if (!row_inb && !dv_end) begin
                    r_dv <= r_dv + DB'(1);
                end
            end
            S_RD: begin
                r_inb <= col_inb;
                r_wt  <= wt_h;
            end
            S_ACC: begin
                if (r_inb) begin
                    r_hdot <= r_hdot + DIVD_W'(prod_h);
                    r_hsum <= r_hsum + DIVS_W'(r_wt);
                end
                if (r_dh == '0) begin
                    r_cpix <= r_rdata;
                end
                if (!dh_end) begin
                    r_dh <= r_dh + DB'(1);
                end
            end
            S_HDIV: begin
                if (r_hsum == '0) begin
                    r_hval <= {r_cpix, FRAC_BITS'(0)};
                end
            end
            S_HWAIT: begin
                if (div_done) begin
                    r_hval <= div_quot[HV_W-1:0];
                end
            end
            S_VACC: begin
                r_vdot <= r_vdot + DIVD_W'(prod_v);
                r_vsum <= r_vsum + DIVS_W'(wt_v);
                if (r_dv == '0) begin
                    r_hcen <= r_hval;
                end
                if (!dv_end) begin
                    r_dv <= r_dv + DB'(1);
                end
            end
            S_VDIV: begin
                if (r_vsum == '0) begin
                    r_res <= r_hcen[HV_W-1:FRAC_BITS];
                end
            end
            S_VWAIT: begin
                if (div_done) begin
                    r_res <= div_quot[FRAC_BITS+PIX_W-1:FRAC_BITS];
                end
            end
            S_OUT: begin
                if (load) begin
                    r_out_pix <= r_res;
                    r_out_rl  <= r_task.row_last;
                    r_out_fl  <= r_task.frame_last;
                end
            end
            default: begin
                r_inb <= 1'b0;
            end
        endcase
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.pixel_out  = r_out_pix;
    assign o_out.row_last   = r_out_rl;
    assign o_out.frame_last = r_out_fl;
    assign o_idle           = (r_state == S_IDLE);

    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_HWAIT || r_state == S_VWAIT))
        else $error("divider result with no waiting pass");

    a_frame_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.frame_last) |-> o_out.row_last)
        else $error("frame end not on a row end");

endmodule

// File: hdl/separable_gaussian_blur_unit.sv
// top level of the separable blur unit: register file and front, queue, back
//
//  channel  dir  handshake              carries
//  i_in     in   valid/ready            command, pixel_in
//  o_out    out  valid/ready            pixel_out, row_last, frame_last
//  apb      in   psel/penable, pready   half_window, taps, image_width, image_height
//
// the front takes one item per cycle while the queue has room and, at a frame's start, the back end is empty
// for each result the back end reads every tap of each in-bounds row from the pixel store
// read port, then runs one divide per in-bounds row and one for the column in the shared
// divider, one bit per cycle; a divide whose weight sum is zero is skipped
// a frame's first pixel waits until the back end is empty
// reset is synchronous; the pixel store needs no clearing pass
// a stalled output holds in the result register while the back works on the next item
module separable_gaussian_blur_unit #(
    parameter int MAX_HALF_WINDOW = 4,
    parameter int MAX_WIDTH       = 2048,
    parameter int MAX_HEIGHT      = 2048,
    parameter int FRAC_BITS       = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    gbl_in_if.sink                       i_in,
    gbl_out_if.source                    o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gbl_pkg::ADDR_W-1:0]   paddr,
    input  logic [gbl_pkg::DATA_W-1:0]   pwdata,
    output logic [gbl_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);
    import gbl_pkg::*;

    localparam int HB = $clog2(MAX_HALF_WINDOW + 1);
    localparam int CB = $clog2(MAX_WIDTH);
    localparam int RB = $clog2(MAX_HEIGHT);

    logic [2:0]  r_half;
    t_taps       r_taps;
    logic [11:0] r_width;
    logic [11:0] r_height;

    logic        wr;
    logic [2:0]  reg_sel;

    t_task       push_task, pop_task;
    logic        push, pop, q_full, q_valid, back_idle;
    t_pix_wr     pix_wr;
    logic [HB-1:0] fr_half;
    logic [CB:0]   fr_w;
    logic [RB:0]   fr_h;

    assign pready  = 1'b1;
    assign wr      = psel && penable && pwrite;
    assign reg_sel = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half    <= 3'd0;
            r_taps[0] <= 16'hFFFF;
            r_taps[1] <= '0;
            r_taps[2] <= '0;
            r_taps[3] <= '0;
            r_taps[4] <= '0;
            r_width   <= 12'd640;
            r_height  <= 12'd480;
        end else if (wr) begin
            case (reg_sel)
                REG_HALF:   r_half    <= pwdata[2:0];
                REG_TAP_C:  r_taps[0] <= pwdata[15:0];
                REG_TAP_1:  r_taps[1] <= pwdata[15:0];
                REG_TAP_2:  r_taps[2] <= pwdata[15:0];
                REG_TAP_3:  r_taps[3] <= pwdata[15:0];
                REG_TAP_4:  r_taps[4] <= pwdata[15:0];
                REG_WIDTH:  r_width   <= pwdata[11:0];
                REG_HEIGHT: r_height  <= pwdata[11:0];
                default:    r_half    <= r_half;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_HALF:   prdata = DATA_W'(r_half);
            REG_TAP_C:  prdata = DATA_W'(r_taps[0]);
            REG_TAP_1:  prdata = DATA_W'(r_taps[1]);
            REG_TAP_2:  prdata = DATA_W'(r_taps[2]);
            REG_TAP_3:  prdata = DATA_W'(r_taps[3]);
            REG_TAP_4:  prdata = DATA_W'(r_taps[4]);
            REG_WIDTH:  prdata = DATA_W'(r_width);
            REG_HEIGHT: prdata = DATA_W'(r_height);
            default:    prdata = '0;
        endcase
    end

    gbl_front #(
        .MAX_HALF_WINDOW (MAX_HALF_WINDOW),
        .MAX_WIDTH       (MAX_WIDTH),
        .MAX_HEIGHT      (MAX_HEIGHT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_half       (r_half),
        .i_width      (r_width),
        .i_height     (r_height),
        .i_back_quiet (back_idle && !q_valid),
        .i_q_full     (q_full),
        .o_task       (push_task),
        .o_push       (push),
        .o_wr         (pix_wr),
        .o_fr_half    (fr_half),
        .o_fr_w       (fr_w),
        .o_fr_h       (fr_h)
    );

    gbl_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_task),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (pop_task)
    );

    gbl_back #(
        .MAX_HALF_WINDOW (MAX_HALF_WINDOW),
        .MAX_WIDTH       (MAX_WIDTH),
        .MAX_HEIGHT      (MAX_HEIGHT),
        .FRAC_BITS       (FRAC_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_task    (pop_task),
        .o_pop     (pop),
        .i_wr      (pix_wr),
        .i_fr_half (fr_half),
        .i_fr_w    (fr_w),
        .i_fr_h    (fr_h),
        .i_taps    (r_taps),
        .o_out     (o_out),
        .o_idle    (back_idle)
    );

endmodule

// File: tb/tb_separable_gaussian_blur_unit.sv
// testbench of the separable blur unit: directed and random frames checked against a built-in predictor
module tb_separable_gaussian_blur_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import gbl_pkg::*;

    localparam int LIMIT_CYCLES = 6000000;
    localparam int SETTLE       = 600;
    localparam int MAX_H        = 4;
    localparam int MAX_W        = 2048;
    localparam int MAX_HT       = 2048;
    localparam int FRAC         = 8;

    typedef struct {
        bit       cmd;
        bit [7:0] px;
    } blur_item_t;

    typedef struct {
        logic [7:0] pix;
        logic       row_last;
        logic       frame_last;
    } blur_result_t;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;

    gbl_in_if  in_if ();
    gbl_out_if out_if ();

    separable_gaussian_blur_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    blur_item_t   pending_items[$];
    blur_result_t expected_pixels[$];
    int           errors = 0;
    int           items_queued = 0;
    int           items_taken = 0;
    int           real_items = 0;
    longint       cycles = 0;
    bit           in_taken = 0;
    bit           no_idle = 0;
    bit           out_hold = 0;
    int           send_gap = 0;
    int           out_gap = 0;

    // predictor state
    int unsigned cfg_half, cfg_w, cfg_h;
    int unsigned taps[5];
    int unsigned fr_k, fr_w, fr_h;
    int unsigned in_col, in_row, out_col, out_row;
    byte unsigned frame_px[int];

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    function automatic int unsigned tap_at(input int d);
        if (d < 0) d = -d;
        if (d <= 4) return taps[d];
        return 0;
    endfunction

    function automatic int unsigned px_at(input int r, input int c);
        int idx;
        idx = r * fr_w + c;
        if (frame_px.exists(idx)) return frame_px[idx];
        return 0;
    endfunction

    function automatic longint unsigned row_blur(input int r, input int c);
        longint unsigned dot;
        longint unsigned sum;
        int cc;
        dot = 0;
        sum = 0;
        for (int d = -int'(fr_k); d <= int'(fr_k); d++) begin
            cc = c + d;
            if (cc >= 0 && cc < int'(fr_w)) begin
                dot += longint'(px_at(r, cc)) * tap_at(d);
                sum += tap_at(d);
            end
        end
        if (sum == 0) return longint'(px_at(r, c)) << FRAC;
        return (dot << FRAC) / sum;
    endfunction

    function automatic bit [7:0] col_blur(input int r, input int c);
        longint unsigned dot;
        longint unsigned sum;
        int rr;
        dot = 0;
        sum = 0;
        for (int d = -int'(fr_k); d <= int'(fr_k); d++) begin
            rr = r + d;
            if (rr >= 0 && rr < int'(fr_h)) begin
                dot += row_blur(rr, c) * tap_at(d);
                sum += tap_at(d);
            end
        end
        if (sum == 0) return 8'(row_blur(r, c) >> FRAC);
        return 8'((dot / sum) >> FRAC);
    endfunction

    function automatic void latch_geometry();
        fr_w = (cfg_w < 1) ? 1 : ((cfg_w > MAX_W) ? MAX_W : cfg_w);
        fr_h = (cfg_h < 1) ? 1 : ((cfg_h > MAX_HT) ? MAX_HT : cfg_h);
        fr_k = (cfg_half > MAX_H) ? MAX_H : cfg_half;
        frame_px.delete();
    endfunction

    function automatic void emit_pixel(input int unsigned total);
        blur_result_t res;
        int unsigned pos;
        res.pix = col_blur(out_row, out_col);
        res.row_last = (out_col == fr_w - 1);
        pos = out_row * fr_w + out_col + 1;
        res.frame_last = (pos == total);
        expected_pixels.push_back(res);
        if (pos == total) begin
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
        end else if (++out_col >= fr_w) begin
            out_col = 0;
            out_row++;
        end
    endfunction

    function automatic void predict_blur(input bit cmd, input bit [7:0] px);
        int unsigned total, in_pos, out_pos, lag;
        in_pos = in_row * fr_w + in_col;
        out_pos = out_row * fr_w + out_col;
        if (cmd == CMD_PIXEL && in_pos == 0 && out_pos == 0) latch_geometry();
        total = fr_w * fr_h;
        lag = fr_k * fr_w + fr_k;
        if (cmd == CMD_PIXEL) begin
            if (in_pos >= total) return;
            frame_px[in_pos] = px;
            if (++in_col >= fr_w) begin
                in_col = 0;
                in_row++;
            end
            in_pos++;
            if (in_pos - out_pos <= lag) return;
            emit_pixel(total);
        end else begin
            if (in_pos < total || out_pos >= total) return;
            emit_pixel(total);
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // input side
    always @(posedge i_clk) begin
        in_taken = in_if.valid && in_if.ready;
        if (i_rst_n && in_taken) begin
            predict_blur(in_if.command, in_if.pixel_in);
            items_taken++;
        end
    end

    always @(negedge i_clk) begin
        blur_item_t it;
        if (!(in_if.valid && !in_taken)) begin
            if (send_gap > 0 || pending_items.size() == 0 || !i_rst_n) begin
                if (send_gap > 0) send_gap--;
                in_if.valid <= 1'b0;
            end else begin
                it = pending_items.pop_front();
                in_if.valid <= 1'b1;
                in_if.command <= it.cmd;
                in_if.pixel_in <= it.px;
                send_gap = no_idle ? 0 : pick_gap();
            end
        end
        if (out_gap > 0) begin
            out_gap--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= !out_hold;
            out_gap = no_idle ? 0 : pick_gap();
        end
    end

    // output side
    always @(posedge i_clk) begin
        blur_result_t want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_pixels.size() == 0) begin
                report("unexpected pixel", out_if.pixel_out, -1);
            end else begin
                want = expected_pixels.pop_front();
                if (out_if.pixel_out !== want.pix) report("pixel_out", out_if.pixel_out, want.pix);
                if (out_if.row_last !== want.row_last)
                    report("row_last", out_if.row_last, want.row_last);
                if (out_if.frame_last !== want.frame_last)
                    report("frame_last", out_if.frame_last, want.frame_last);
            end
        end
    end

    // long receiver hold-off while the sender keeps offering items
    initial begin
        wait (items_taken > 300);
        @(posedge i_clk);
        out_hold = 1'b1;
        repeat (6000) @(posedge i_clk);
        out_hold = 1'b0;
    end

    task automatic reg_write(input logic [2:0] idx, input int unsigned val);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'({idx, 2'b00});
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_HALF:   cfg_half = val & 32'h7;
            REG_TAP_C:  taps[0] = val & 32'hFFFF;
            REG_TAP_1:  taps[1] = val & 32'hFFFF;
            REG_TAP_2:  taps[2] = val & 32'hFFFF;
            REG_TAP_3:  taps[3] = val & 32'hFFFF;
            REG_TAP_4:  taps[4] = val & 32'hFFFF;
            REG_WIDTH:  cfg_w = val & 32'hFFF;
            REG_HEIGHT: cfg_h = val & 32'hFFF;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (items_taken != items_queued || expected_pixels.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    function automatic void push_item(input bit cmd, input bit [7:0] px);
        blur_item_t it;
        it.cmd = cmd;
        it.px = px;
        pending_items.push_back(it);
        items_queued++;
    endfunction

    function automatic bit [7:0] pick_pixel();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 8'h00;
        if (r < 20) return 8'hFF;
        return 8'($urandom);
    endfunction

    task automatic run_frames(input int unsigned half, input int unsigned tc, input int unsigned t1,
                              input int unsigned t2, input int unsigned t3, input int unsigned t4,
                              input int unsigned w, input int unsigned h, input int nframes,
                              input bit noisy);
        int unsigned ew, eh, ek, total, left;
        wait_drained();
        no_idle = ($urandom_range(0, 3) == 0);
        reg_write(REG_HALF, half);
        reg_write(REG_TAP_C, tc);
        reg_write(REG_TAP_1, t1);
        reg_write(REG_TAP_2, t2);
        reg_write(REG_TAP_3, t3);
        reg_write(REG_TAP_4, t4);
        reg_write(REG_WIDTH, w);
        reg_write(REG_HEIGHT, h);
        ew = (w < 1) ? 1 : ((w > MAX_W) ? MAX_W : w);
        eh = (h < 1) ? 1 : ((h > MAX_HT) ? MAX_HT : h);
        ek = (half > MAX_H) ? MAX_H : half;
        total = ew * eh;
        left = ek * ew + ek;
        if (left > total) left = total;
        for (int f = 0; f < nframes; f++) begin
            for (int p = 0; p < int'(total); p++) begin
                // drains inside an unfinished frame are dropped
                if (noisy && $urandom_range(0, 19) == 0) push_item(1'b1, 8'($urandom));
                push_item(CMD_PIXEL, pick_pixel());
                real_items++;
            end
            for (int d = 0; d < int'(left); d++) begin
                // stray pixels while outputs are pending are dropped
                if (noisy && $urandom_range(0, 9) == 0) push_item(CMD_PIXEL, 8'($urandom));
                push_item(1'b1, 8'($urandom));
                real_items++;
            end
            if (noisy && $urandom_range(0, 3) == 0) push_item(1'b1, 8'($urandom));
        end
    endtask

    function automatic int unsigned pick_tap();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 0;
        if (r == 1) return 16'hFFFF;
        return $urandom_range(0, 65535);
    endfunction

    initial begin
        int unsigned hw;
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.command = CMD_PIXEL;
        in_if.pixel_in = 8'h00;
        out_if.ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cfg_half = 0;
        taps[0] = 65535;
        for (int i = 1; i < 5; i++) taps[i] = 0;
        cfg_w = 640;
        cfg_h = 480;
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
        latch_geometry();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // pass-through, saturated half width with full taps, zero weight sum, 1x1 frame
        run_frames(0, 65535, 0, 0, 0, 0, 4, 2, 1, 1'b1);
        run_frames(7, 65535, 65535, 65535, 65535, 65535, 5, 3, 1, 1'b1);
        run_frames(2, 0, 0, 0, 0, 0, 3, 2, 1, 1'b1);
        run_frames(4, 1000, 3000, 0, 77, 65535, 0, 0, 2, 1'b1);

        while (real_items < 1250) begin
            hw = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
            run_frames(hw, pick_tap(), pick_tap(), pick_tap(), pick_tap(), pick_tap(),
                       $urandom_range(1, 12), $urandom_range(1, 8), $urandom_range(1, 3),
                       $urandom_range(0, 1));
        end

        wait_drained();
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: separable_gaussian_blur_unit.f
hdl/gbl_pkg.sv
hdl/gbl_stream_if.sv
hdl/gbl_front.sv
hdl/gbl_fifo.sv
hdl/gbl_div.sv
hdl/gbl_back.sv
hdl/separable_gaussian_blur_unit.sv
tb/tb_separable_gaussian_blur_unit.sv
